// ----- rtl/rcfl_pkg.sv -----
// Shared types, constants and register codes of the frame link and arming controller.
`timescale 1ns / 1ps

package rcfl_pkg;

    // Payload buffering
    localparam int PAYLOAD_BYTES = 32;
    localparam int FRAME_LEN     = 17;
    localparam int SUM_LEN       = 13;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(FRAME_LEN);
    localparam int SUM_W         = 12;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEADER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_HIGH_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_LOW_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS        = 3'd4;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [23:0] FRAME_HEADER_RST   = 24'd0;
    localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;
    localparam logic [15:0] ARM_HIGH_LEVEL_RST = 16'd900;
    localparam logic [15:0] ARM_LOW_LEVEL_RST  = 16'd100;
    localparam logic [15:0] HOLD_MS_RST        = 16'd1000;

    // Fix-height request value that toggles the mode
    localparam logic [7:0] HEIGHT_TOGGLE = 8'd1;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_HOLD   = 2'd2,
        MODE_FAIL   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ARM_FREE      = 3'd0,
        ARM_HIGH      = 3'd1,
        ARM_LEFT_HIGH = 3'd2,
        ARM_LOW       = 3'd3,
        ARM_UNLOCKED  = 3'd4
    } arm_t;

    // Decoded frame from the payload buffer
    typedef struct packed {
        logic        ok;
        logic [15:0] throttle;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [7:0]  shutdown;
        logic [7:0]  height;
    } frame_t;

    // Settings used by the link and mode controller
    typedef struct packed {
        logic [7:0]  max_retries;
        logic [15:0] arm_high_level;
        logic [15:0] arm_low_level;
        logic [15:0] hold_ms;
    } ctrl_cfg_t;

    // Controller state after an evaluation
    typedef struct packed {
        logic [15:0] throttle;
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [7:0]  shutdown;
        logic        link_up;
        mode_t       flight_mode;
        arm_t        arm_phase;
    } status_t;

endpackage

// ----- rtl/rc_frame_link_arm_controller.sv -----
// Top level: stream ports, configuration registers, input and result registers.
`timescale 1ns / 1ps

// Radio frame checker, link monitor and arming / flight-mode controller.
// Input stream: s_axis_tuser is the command (0 payload byte, 1 end of attempt);
// s_axis_tdata carries the payload byte and the millisecond tick. Payload
// bytes produce no result; every end-of-attempt transfer produces exactly one
// result transfer on the m_axis side with the frame verdict in m_axis_tuser
// and the latched channels, link, mode and arming phase in m_axis_tdata.
// Throughput: one input transfer per cycle, bytes and evaluations alike, while
// the result stream does not stall; the checksum is accumulated as bytes
// arrive so the evaluation is a single pass. An end-of-attempt transfer is
// captured in the input register, which feeds the evaluation logic that loads
// the result register driving m_axis.
// When the receiver stalls, the result register holds; payload bytes keep
// flowing and a further end-of-attempt waits in the input register, which
// in turn stalls s_axis_tready.
// Configuration writes on cfg_* are always accepted (cfg_ready high) and
// must be issued only while the block is idle.
// Reset (aresetn low, synchronous) empties the buffer and both registers,
// drops the link, sets mode idle, arming free and registers to defaults.
module rc_frame_link_arm_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], now_ms[39:8]
    input  logic        s_axis_tuser,   // command[0]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // throttle[15:0], yaw[31:16], pitch[47:32],
                                        // roll[63:48], shutdown[71:64], link_up[72],
                                        // flight_mode[74:73], arm_phase[77:75], zero[79:78]
    output logic        m_axis_tuser    // frame_ok[0]
);

    logic [23:0]         frame_header_reg;
    rcfl_pkg::ctrl_cfg_t cfg_reg;

    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [7:0]          in_byte_reg;
    logic [31:0]         in_now_reg;

    logic                out_valid_reg;
    logic [79:0]         out_data_reg;
    logic                out_ok_reg;

    logic                advance;
    logic                byte_en;
    logic                eval_en;
    rcfl_pkg::frame_t    frame;
    rcfl_pkg::status_t   status_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_header_reg       <= rcfl_pkg::FRAME_HEADER_RST;
            cfg_reg.max_retries    <= rcfl_pkg::MAX_RETRIES_RST;
            cfg_reg.arm_high_level <= rcfl_pkg::ARM_HIGH_LEVEL_RST;
            cfg_reg.arm_low_level  <= rcfl_pkg::ARM_LOW_LEVEL_RST;
            cfg_reg.hold_ms        <= rcfl_pkg::HOLD_MS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rcfl_pkg::CFG_FRAME_HEADER:   frame_header_reg       <= cfg_data;
                rcfl_pkg::CFG_MAX_RETRIES:    cfg_reg.max_retries    <= cfg_data[7:0];
                rcfl_pkg::CFG_ARM_HIGH_LEVEL: cfg_reg.arm_high_level <= cfg_data[15:0];
                rcfl_pkg::CFG_ARM_LOW_LEVEL:  cfg_reg.arm_low_level  <= cfg_data[15:0];
                rcfl_pkg::CFG_HOLD_MS:        cfg_reg.hold_ms        <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Bytes always advance; an evaluation advances when the result register frees
    assign advance = in_valid_reg
                  && (in_cmd_reg == rcfl_pkg::CMD_BYTE || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign byte_en = advance && (in_cmd_reg == rcfl_pkg::CMD_BYTE);
    assign eval_en = advance && (in_cmd_reg == rcfl_pkg::CMD_EVAL);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata[7:0];
            in_now_reg  <= s_axis_tdata[39:8];
        end
    end

    rcfl_frame_buf u_frame_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .data_byte    (in_byte_reg),
        .clear        (eval_en),
        .frame_header (frame_header_reg),
        .frame        (frame)
    );

    rcfl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .eval_en     (eval_en),
        .now_ms      (in_now_reg),
        .frame       (frame),
        .cfg         (cfg_reg),
        .status_next (status_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eval_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en) begin
            out_ok_reg   <= frame.ok;
            out_data_reg <= {2'b00,
                             status_next.arm_phase,
                             status_next.flight_mode,
                             status_next.link_up,
                             status_next.shutdown,
                             status_next.roll,
                             status_next.pitch,
                             status_next.yaw,
                             status_next.throttle};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ok_reg;

    a_eval_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !eval_en)
        else $error("evaluation overwrote a pending result");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_en |=> out_valid_reg)
        else $error("evaluation produced no result");

    a_byte_never_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_cmd_reg == rcfl_pkg::CMD_BYTE |-> advance)
        else $error("payload byte held in the input register");

endmodule

// ----- rtl/rcfl_frame_buf.sv -----
// Payload byte buffer with running checksum and frame check.
`timescale 1ns / 1ps

module rcfl_frame_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           data_byte,
    input  logic                 clear,
    input  logic [23:0]          frame_header,
    output rcfl_pkg::frame_t     frame
);

    logic [7:0]                 bytes_reg [rcfl_pkg::FRAME_LEN];
    logic [rcfl_pkg::CNT_W-1:0] cnt_reg;
    logic [rcfl_pkg::SUM_W-1:0] sum_reg;
    logic [rcfl_pkg::IDX_W-1:0] idx;
    logic                       in_frame;
    logic                       in_sum;
    logic                       room;

    assign idx      = cnt_reg[rcfl_pkg::IDX_W-1:0];
    assign room     = cnt_reg < rcfl_pkg::CNT_W'(rcfl_pkg::PAYLOAD_BYTES);
    assign in_frame = cnt_reg < rcfl_pkg::CNT_W'(rcfl_pkg::FRAME_LEN);
    assign in_sum   = cnt_reg < rcfl_pkg::CNT_W'(rcfl_pkg::SUM_LEN);

    // Store bytes by position; clear the whole frame at the end of an attempt
    always_ff @(posedge aclk) begin
        for (int i = 0; i < rcfl_pkg::FRAME_LEN; i++) begin
            if (!aresetn || clear) begin
                bytes_reg[i] <= 8'd0;
            end else if (byte_en && in_frame && idx == rcfl_pkg::IDX_W'(i)) begin
                bytes_reg[i] <= data_byte;
            end
        end
    end

    // Count bytes and keep the running sum of the checksummed bytes
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            cnt_reg <= '0;
            sum_reg <= '0;
        end else if (byte_en && room) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (in_sum) begin
                sum_reg <= sum_reg + rcfl_pkg::SUM_W'(data_byte);
            end
        end
    end

    // Header, zero-byte and checksum compare, and channel decode; the sum fits in the two low bytes of the word
    always_comb begin
        frame.ok = (bytes_reg[0] != 8'd0)
                && (bytes_reg[0] == frame_header[23:16])
                && (bytes_reg[1] == frame_header[15:8])
                && (bytes_reg[2] == frame_header[7:0])
                && (bytes_reg[13] == 8'd0)
                && (bytes_reg[14] == 8'd0)
                && ({bytes_reg[15], bytes_reg[16]} == 16'(sum_reg));
        frame.throttle = {bytes_reg[3], bytes_reg[4]};
        frame.yaw      = {bytes_reg[5], bytes_reg[6]};
        frame.pitch    = {bytes_reg[7], bytes_reg[8]};
        frame.roll     = {bytes_reg[9], bytes_reg[10]};
        frame.shutdown = bytes_reg[11];
        frame.height   = bytes_reg[12];
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rcfl_pkg::CNT_W'(rcfl_pkg::PAYLOAD_BYTES))
        else $error("byte count beyond payload size");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (cnt_reg == '0) && (sum_reg == '0) && !frame.ok)
        else $error("buffer not empty after attempt end");

    a_sum_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear && !in_sum |=> $stable(sum_reg))
        else $error("checksum moved past the summed bytes");

endmodule

// ----- rtl/rcfl_ctrl.sv -----
// Channel latch, link retry counter, arming sequence and flight-mode machine.
`timescale 1ns / 1ps

module rcfl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                eval_en,
    input  logic [31:0]         now_ms,
    input  rcfl_pkg::frame_t    frame,
    input  rcfl_pkg::ctrl_cfg_t cfg,
    output rcfl_pkg::status_t   status_next
);

    logic [15:0]     throttle_reg, yaw_reg, pitch_reg, roll_reg;
    logic [15:0]     throttle_next, yaw_next, pitch_next, roll_next;
    logic [7:0]      shutdown_reg, shutdown_next;
    logic [7:0]      height_reg, height_next;
    logic            link_reg, link_next;
    logic [7:0]      fail_reg, fail_next;
    logic [7:0]      fail_inc;
    rcfl_pkg::mode_t mode_reg, mode_next;
    rcfl_pkg::arm_t  arm_reg, arm_next, arm_step;
    logic [31:0]     high_start_reg, high_start_next;
    logic [31:0]     low_start_reg, low_start_next;
    logic [31:0]     high_elapsed, low_elapsed;

    assign fail_inc     = fail_reg + 8'd1;
    assign high_elapsed = now_ms - high_start_reg;
    assign low_elapsed  = now_ms - low_start_reg;

    // Latch the frame and count failed attempts
    always_comb begin
        throttle_next = throttle_reg;
        yaw_next      = yaw_reg;
        pitch_next    = pitch_reg;
        roll_next     = roll_reg;
        shutdown_next = shutdown_reg;
        height_next   = height_reg;
        link_next     = link_reg;
        fail_next     = fail_reg;
        if (frame.ok) begin
            throttle_next = frame.throttle;
            yaw_next      = frame.yaw;
            pitch_next    = frame.pitch;
            roll_next     = frame.roll;
            shutdown_next = frame.shutdown;
            height_next   = frame.height;
            link_next     = 1'b1;
            fail_next     = 8'd0;
        end else if (fail_inc >= cfg.max_retries) begin
            link_next = 1'b0;
            fail_next = 8'd0;
        end else begin
            fail_next = fail_inc;
        end
    end

    // Arming step on the freshly latched throttle
    always_comb begin
        arm_step        = arm_reg;
        high_start_next = high_start_reg;
        low_start_next  = low_start_reg;
        unique case (arm_reg)
            rcfl_pkg::ARM_FREE: begin
                if (throttle_next >= cfg.arm_high_level) begin
                    arm_step        = rcfl_pkg::ARM_HIGH;
                    high_start_next = now_ms;
                end
            end
            rcfl_pkg::ARM_HIGH: begin
                if (throttle_next < cfg.arm_high_level) begin
                    arm_step = (high_elapsed >= 32'(cfg.hold_ms))
                             ? rcfl_pkg::ARM_LEFT_HIGH : rcfl_pkg::ARM_FREE;
                end
            end
            rcfl_pkg::ARM_LEFT_HIGH: begin
                if (throttle_next <= cfg.arm_low_level) begin
                    arm_step       = rcfl_pkg::ARM_LOW;
                    low_start_next = now_ms;
                end
            end
            rcfl_pkg::ARM_LOW: begin
                if (low_elapsed <= 32'(cfg.hold_ms)) begin
                    arm_step = (throttle_next > cfg.arm_low_level)
                             ? rcfl_pkg::ARM_FREE : rcfl_pkg::ARM_UNLOCKED;
                end
            end
            default: begin
                arm_step = arm_reg;
            end
        endcase
    end

    // Flight-mode machine
    always_comb begin
        mode_next = mode_reg;
        arm_next  = arm_reg;
        unique case (mode_reg)
            rcfl_pkg::MODE_IDLE: begin
                arm_next = arm_step;
                if (arm_step == rcfl_pkg::ARM_UNLOCKED) begin
                    mode_next = rcfl_pkg::MODE_NORMAL;
                    arm_next  = rcfl_pkg::ARM_FREE;
                end
            end
            rcfl_pkg::MODE_NORMAL, rcfl_pkg::MODE_HOLD: begin
                if (height_next == rcfl_pkg::HEIGHT_TOGGLE) begin
                    mode_next = (mode_reg == rcfl_pkg::MODE_NORMAL)
                              ? rcfl_pkg::MODE_HOLD : rcfl_pkg::MODE_NORMAL;
                end
                if (!link_next) begin
                    mode_next = rcfl_pkg::MODE_FAIL;
                end
            end
            default: begin
                mode_next = rcfl_pkg::MODE_IDLE;
            end
        endcase
    end

    // Commit the new state on each evaluation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            throttle_reg   <= '0;
            yaw_reg        <= '0;
            pitch_reg      <= '0;
            roll_reg       <= '0;
            shutdown_reg   <= '0;
            height_reg     <= '0;
            link_reg       <= 1'b0;
            fail_reg       <= '0;
            mode_reg       <= rcfl_pkg::MODE_IDLE;
            arm_reg        <= rcfl_pkg::ARM_FREE;
            high_start_reg <= '0;
            low_start_reg  <= '0;
        end else if (eval_en) begin
            throttle_reg   <= throttle_next;
            yaw_reg        <= yaw_next;
            pitch_reg      <= pitch_next;
            roll_reg       <= roll_next;
            shutdown_reg   <= shutdown_next;
            link_reg       <= link_next;
            fail_reg       <= fail_next;
            mode_reg       <= mode_next;
            arm_reg        <= arm_next;
            if (mode_reg == rcfl_pkg::MODE_IDLE) begin
                high_start_reg <= high_start_next;
                low_start_reg  <= low_start_next;
            end
            // Consume the fix-height request once it has toggled the mode
            if ((mode_reg == rcfl_pkg::MODE_NORMAL || mode_reg == rcfl_pkg::MODE_HOLD)
                && height_next == rcfl_pkg::HEIGHT_TOGGLE) begin
                height_reg <= 8'd0;
            end else begin
                height_reg <= height_next;
            end
        end
    end

    always_comb begin
        status_next.throttle    = throttle_next;
        status_next.yaw         = yaw_next;
        status_next.pitch       = pitch_next;
        status_next.roll        = roll_next;
        status_next.shutdown    = shutdown_next;
        status_next.link_up     = link_next;
        status_next.flight_mode = mode_next;
        status_next.arm_phase   = arm_next;
    end

    a_unlock_transient: assert property (@(posedge aclk) disable iff (!aresetn)
        arm_reg != rcfl_pkg::ARM_UNLOCKED)
        else $error("unlocked arming phase was stored");

    a_ok_links: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_en && frame.ok |=> link_reg && (fail_reg == 8'd0))
        else $error("valid frame did not bring the link up");

    a_fail_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_en && mode_reg == rcfl_pkg::MODE_FAIL |=> mode_reg == rcfl_pkg::MODE_IDLE)
        else $error("fail mode did not return to idle");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !eval_en |=> $stable(mode_reg) && $stable(arm_reg) && $stable(link_reg))
        else $error("state changed without an evaluation");

endmodule
